// ===== design/obb_pkg.sv =====
package obb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_ITEMS = 11;

    typedef enum logic {
        KIND_CORNER = 1'b0,
        KIND_AXIS   = 1'b1
    } item_kind_t;

    typedef enum logic [2:0] {
        AXIS_RIGHT = 3'd0,
        AXIS_UP    = 3'd1,
        AXIS_FRONT = 3'd2
    } axis_idx_t;

    typedef enum logic [1:0] {
        REG_HALF_WIDTH  = 2'd0,
        REG_HALF_HEIGHT = 2'd1,
        REG_HALF_DEPTH  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] mat_r0_c0;
        logic signed [31:0] mat_r0_c1;
        logic signed [31:0] mat_r0_c2;
        logic signed [31:0] mat_r1_c0;
        logic signed [31:0] mat_r1_c1;
        logic signed [31:0] mat_r1_c2;
        logic signed [31:0] mat_r2_c0;
        logic signed [31:0] mat_r2_c1;
        logic signed [31:0] mat_r2_c2;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } in_item_t;

    typedef struct packed {
        logic               item_kind;
        logic [2:0]         item_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               overflow;
        logic               last;
    } out_item_t;

    // Corner sign table: bit 2 x, bit 1 y, bit 0 z; a set bit means positive.
    function automatic logic [2:0] corner_signs(input logic [2:0] c);
        logic [2:0] s;
        case (c)
            3'd0: s = 3'b000;
            3'd1: s = 3'b001;
            3'd2: s = 3'b101;
            3'd3: s = 3'b100;
            3'd4: s = 3'b010;
            3'd5: s = 3'b011;
            3'd6: s = 3'b111;
            3'd7: s = 3'b110;
            default: s = 3'b000;
        endcase
        return s;
    endfunction

endpackage

// ===== design/obb_axes_and_corner_transform_top.sv =====
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_item_t, one transform
// out       output     out_valid / out_ready out_item_t, eleven per transform
// cfg       input      cfg_we                cfg_index, cfg_data
//
// Corner components run through one 33x32 multiplier; the three axes run
// through one shared iterative normalizer.
// A two-entry input queue accepts new transactions while the back end works.
// Reset is asynchronous and active low; output stalls hold the back end.
module obb_axes_and_corner_transform_top
    import obb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    logic        q_valid, q_pop;
    in_item_t    q_data;
    logic [30:0] hw_reg, hh_reg, hd_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= 31'd65536;
            hh_reg <= 31'd65536;
            hd_reg <= 31'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_WIDTH:  hw_reg <= cfg_data;
                REG_HALF_HEIGHT: hh_reg <= cfg_data;
                REG_HALF_DEPTH:  hd_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    obb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_data   (q_data)
    );

    obb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_data      (q_data),
        .half_width  (hw_reg),
        .half_height (hh_reg),
        .half_depth  (hd_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );
endmodule

// ===== design/obb_front.sv =====
// Input stage: accepts a transaction into a two-entry queue.
module obb_front
    import obb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_pop,
    output in_item_t q_data
);
    in_item_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== design/obb_norm.sv =====
// Sequential vector normalizer: shift to range (at most 30 left shifts), sum
// squares, square root, then three restoring divisions. A zero vector goes
// straight from the shift phase to done.
module obb_norm
    import obb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [32:0] vx,
    input  logic signed [32:0] vy,
    input  logic signed [32:0] vz,
    output logic               done,
    output logic signed [31:0] rx,
    output logic signed [31:0] ry,
    output logic signed [31:0] rz
);
    typedef enum logic [2:0] {
        N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE
    } nstate_t;

    nstate_t     st_reg, st_next;
    logic [31:0] m_reg [3];
    logic [2:0]  neg_reg;
    logic [65:0] acc_reg;
    logic [1:0]  ci_reg;
    logic [65:0] sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [31:0] len_reg;
    logic [48:0] num_reg;
    logic [48:0] rem_reg;
    logic [48:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic [31:0] q_reg [3];
    logic [31:0] mx;
    logic [63:0] sqv;
    logic [31:0] msel;

    localparam int QW = 32 + FRAC_BITS + 1;

    assign mx = (m_reg[0] | m_reg[1] | m_reg[2]);
    assign msel = m_reg[ci_reg];
    assign sqv = msel * msel;
    assign done = (st_reg == N_DONE);
    assign rx = neg_reg[0] ? -q_reg[0] : q_reg[0];
    assign ry = neg_reg[1] ? -q_reg[1] : q_reg[1];
    assign rz = neg_reg[2] ? -q_reg[2] : q_reg[2];

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            N_IDLE:  if (start) st_next = N_SHIFT;
            N_SHIFT:
            begin
                if (mx == 32'd0) st_next = N_DONE;
                else if (mx[31:30] != 2'b00) st_next = N_SQ;
            end
            N_SQ:    if (ci_reg == 2'd2) st_next = N_SQRT;
            N_SQRT:  if (sq_bit_reg == 66'd0) st_next = N_DIV;
            N_DIV:   if (dcnt_reg == 6'd0 && ci_reg == 2'd2) st_next = N_DONE;
            N_DONE:  st_next = N_IDLE;
            default: st_next = N_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= N_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Datapath: one step per cycle in each phase.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    neg_reg  <= {vz[32], vy[32], vx[32]};
                    m_reg[0] <= 32'(vx[32] ? -vx : vx);
                    m_reg[1] <= 32'(vy[32] ? -vy : vy);
                    m_reg[2] <= 32'(vz[32] ? -vz : vz);
                    q_reg[0] <= 32'd0;
                    q_reg[1] <= 32'd0;
                    q_reg[2] <= 32'd0;
                    ci_reg   <= 2'd0;
                    acc_reg  <= 66'd0;
                end
            end
            N_SHIFT:
            begin
                if (mx != 32'd0 && mx[31:30] == 2'b00)
                begin
                    m_reg[0] <= m_reg[0] << 1;
                    m_reg[1] <= m_reg[1] << 1;
                    m_reg[2] <= m_reg[2] << 1;
                end
            end
            N_SQ:
            begin
                if (ci_reg == 2'd2)
                begin
                    sq_n_reg   <= acc_reg + {2'b00, sqv};
                    sq_res_reg <= 66'd0;
                    sq_bit_reg <= 66'd1 << 64;
                    ci_reg     <= 2'd0;
                end
                else
                begin
                    acc_reg <= acc_reg + {2'b00, sqv};
                    ci_reg  <= ci_reg + 2'd1;
                end
            end
            N_SQRT:
            begin
                if (sq_bit_reg == 66'd0)
                begin
                    len_reg  <= sq_res_reg[31:0];
                    num_reg  <= ({17'd0, m_reg[0]} << FRAC_BITS)
                                + {18'd0, sq_res_reg[31:1]};
                    rem_reg  <= 49'd0;
                    quo_reg  <= 49'd0;
                    dcnt_reg <= 6'(QW);
                end
                else
                begin
                    if (sq_n_reg >= sq_res_reg + sq_bit_reg)
                    begin
                        sq_n_reg   <= sq_n_reg - (sq_res_reg + sq_bit_reg);
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
            end
            N_DIV:
            begin
                if (dcnt_reg == 6'd0)
                begin
                    q_reg[ci_reg] <= quo_reg[31:0];
                    if (ci_reg != 2'd2)
                    begin
                        ci_reg   <= ci_reg + 2'd1;
                        num_reg  <= ({17'd0, m_reg[ci_reg + 2'd1]} << FRAC_BITS)
                                    + {18'd0, len_reg[31:1]};
                        rem_reg  <= 49'd0;
                        quo_reg  <= 49'd0;
                        dcnt_reg <= 6'(QW);
                    end
                end
                else
                begin
                    if ({rem_reg[47:0], num_reg[48]} >= {17'd0, len_reg})
                    begin
                        rem_reg <= {rem_reg[47:0], num_reg[48]} - {17'd0, len_reg};
                        quo_reg <= {quo_reg[47:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[47:0], num_reg[48]};
                        quo_reg <= {quo_reg[47:0], 1'b0};
                    end
                    num_reg  <= {num_reg[47:0], 1'b0};
                    dcnt_reg <= dcnt_reg - 6'd1;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== design/obb_back.sv =====
// Execution stage: eight corners, one multiply-accumulate step per cycle, each
// corner waiting for the output to free up, then front, right and up through
// the shared normalizer.
module obb_back
    import obb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  in_item_t    q_data,
    input  logic [30:0] half_width,
    input  logic [30:0] half_height,
    input  logic [30:0] half_depth,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);
    typedef enum logic [3:0] {
        B_IDLE, B_MUL, B_CORNER, B_FSTART, B_FWAIT, B_RSTART, B_RWAIT,
        B_CROSS, B_USTART, B_UWAIT, B_EMIT
    } bstate_t;

    bstate_t            st_reg, st_next;
    logic [2:0]         corner_reg;
    logic [1:0]         col_reg;
    logic [1:0]         row_reg;
    logic signed [79:0] sum_reg;
    logic signed [31:0] p_reg [3];
    logic               ov_reg;
    logic signed [31:0] f_reg [3];
    logic signed [31:0] r_reg [3];
    logic signed [31:0] u_reg [3];
    logic [1:0]         ax_reg;
    logic [1:0]         xc_reg;
    logic               ovalid_reg;
    out_item_t          odata_reg;
    logic               ofree;
    logic               n_start;
    logic signed [32:0] nvx, nvy, nvz;
    logic               n_done;
    logic signed [31:0] nrx, nry, nrz;
    logic [2:0]         sg;
    logic signed [32:0] hsel;
    logic signed [31:0] msel;
    logic signed [64:0] prod;
    logic signed [79:0] rnd;
    logic signed [79:0] withtr;
    logic signed [31:0] tsel;
    logic signed [31:0] sat;
    logic               sat_ov;
    logic signed [31:0] ca, cb, cc, cd;
    logic signed [63:0] xp;

    assign ofree     = !ovalid_reg || out_ready;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    obb_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (n_start),
        .vx    (nvx),
        .vy    (nvy),
        .vz    (nvz),
        .done  (n_done),
        .rx    (nrx),
        .ry    (nry),
        .rz    (nrz)
    );

    // Corner product: one signed half-extent times one matrix entry.
    always_comb
    begin
        sg = corner_signs(corner_reg);
        case (row_reg)
            2'd0: hsel = sg[2] ? $signed({2'b00, half_width}) : -$signed({2'b00, half_width});
            2'd1: hsel = sg[1] ? $signed({2'b00, half_height}) : -$signed({2'b00, half_height});
            default: hsel = sg[0] ? $signed({2'b00, half_depth}) : -$signed({2'b00, half_depth});
        endcase
        case ({row_reg, col_reg})
            4'b0000: msel = q_data.mat_r0_c0;
            4'b0001: msel = q_data.mat_r0_c1;
            4'b0010: msel = q_data.mat_r0_c2;
            4'b0100: msel = q_data.mat_r1_c0;
            4'b0101: msel = q_data.mat_r1_c1;
            4'b0110: msel = q_data.mat_r1_c2;
            4'b1000: msel = q_data.mat_r2_c0;
            4'b1001: msel = q_data.mat_r2_c1;
            default: msel = q_data.mat_r2_c2;
        endcase
        case (col_reg)
            2'd0: tsel = q_data.trans_x;
            2'd1: tsel = q_data.trans_y;
            default: tsel = q_data.trans_z;
        endcase
        prod   = hsel * msel;
        rnd    = (sum_reg + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        withtr = rnd + 80'(tsel);
        if (withtr > 80'sd2147483647)
        begin
            sat = 32'h7fffffff; sat_ov = 1'b1;
        end
        else if (withtr < -80'sd2147483648)
        begin
            sat = 32'h80000000; sat_ov = 1'b1;
        end
        else
        begin
            sat = withtr[31:0]; sat_ov = 1'b0;
        end
    end

    // Cross product term pair for the up axis; one product per cycle.
    always_comb
    begin
        case (xc_reg)
            2'd0:    begin ca = f_reg[1]; cb = r_reg[2]; cc = f_reg[2]; cd = r_reg[1]; end
            2'd1:    begin ca = f_reg[2]; cb = r_reg[0]; cc = f_reg[0]; cd = r_reg[2]; end
            default: begin ca = f_reg[0]; cb = r_reg[1]; cc = f_reg[1]; cd = r_reg[0]; end
        endcase
        if (row_reg == 2'd0)
        begin
            xp = ca * cb;
        end
        else
        begin
            xp = cc * cd;
        end
    end

    // Normalizer operand selection.
    always_comb
    begin
        n_start = (st_reg == B_FSTART) || (st_reg == B_RSTART) || (st_reg == B_USTART);
        case (st_reg)
            B_FSTART:
            begin
                nvx = -33'(q_data.mat_r2_c0);
                nvy = 33'(q_data.mat_r2_c1);
                nvz = 33'(q_data.mat_r2_c2);
            end
            B_RSTART:
            begin
                nvx = -33'(f_reg[2]);
                nvy = 33'sd0;
                nvz = 33'(f_reg[0]);
            end
            default:
            begin
                nvx = 33'(u_reg[0]);
                nvy = 33'(u_reg[1]);
                nvz = 33'(u_reg[2]);
            end
        endcase
    end

    // Sequencer next state.
    always_comb
    begin
        st_next = st_reg;
        q_pop   = 1'b0;
        case (st_reg)
            B_IDLE:   if (q_valid) st_next = B_MUL;
            B_MUL:    if (row_reg == 2'd3) st_next = (col_reg == 2'd2) ? B_CORNER : B_MUL;
            B_CORNER: if (ofree) st_next = (corner_reg == 3'd7) ? B_FSTART : B_MUL;
            B_FSTART: st_next = B_FWAIT;
            B_FWAIT:  if (n_done) st_next = B_RSTART;
            B_RSTART: st_next = B_RWAIT;
            B_RWAIT:  if (n_done) st_next = B_CROSS;
            B_CROSS:  if (xc_reg == 2'd2 && row_reg == 2'd1) st_next = B_USTART;
            B_USTART: st_next = B_UWAIT;
            B_UWAIT:  if (n_done) st_next = B_EMIT;
            B_EMIT:
            begin
                if (ofree && ax_reg == 2'd2)
                begin
                    st_next = B_IDLE;
                    q_pop   = 1'b1;
                end
            end
            default:  st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= B_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_ready)
            begin
                ovalid_reg <= 1'b0;
            end
            if ((st_reg == B_CORNER || st_reg == B_EMIT) && ofree)
            begin
                ovalid_reg <= 1'b1;
            end
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
            begin
                corner_reg <= 3'd0;
                col_reg    <= 2'd0;
                row_reg    <= 2'd0;
                sum_reg    <= 80'sd0;
                ov_reg     <= 1'b0;
            end
            B_MUL:
            begin
                // Accumulate the three products, then round, translate and saturate.
                if (row_reg == 2'd3)
                begin
                    p_reg[col_reg] <= sat;
                    if (sat_ov) ov_reg <= 1'b1;
                    sum_reg <= 80'sd0;
                    row_reg <= 2'd0;
                    if (col_reg != 2'd2) col_reg <= col_reg + 2'd1;
                end
                else
                begin
                    sum_reg <= sum_reg + 80'(prod);
                    row_reg <= row_reg + 2'd1;
                end
            end
            B_CORNER:
            begin
                if (ofree)
                begin
                    odata_reg <= '{item_kind: KIND_CORNER, item_index: corner_reg,
                                   out_x: p_reg[0], out_y: p_reg[1], out_z: p_reg[2],
                                   overflow: ov_reg, last: 1'b0};
                    corner_reg <= corner_reg + 3'd1;
                    col_reg    <= 2'd0;
                    ov_reg     <= 1'b0;
                end
            end
            B_FWAIT:
            begin
                f_reg[0] <= nrx; f_reg[1] <= nry; f_reg[2] <= nrz;
            end
            B_RWAIT:
            begin
                r_reg[0] <= nrx; r_reg[1] <= nry; r_reg[2] <= nrz;
                xc_reg   <= 2'd0;
                row_reg  <= 2'd0;
                sum_reg  <= 80'sd0;
            end
            B_CROSS:
            begin
                // Adds a*b first, then subtracts c*d and rounds.
                if (row_reg == 2'd0)
                begin
                    sum_reg <= 80'(xp);
                    row_reg <= 2'd1;
                end
                else
                begin
                    u_reg[xc_reg] <= 32'((sum_reg - 80'(xp)
                                    + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
                    row_reg <= 2'd0;
                    xc_reg  <= xc_reg + 2'd1;
                end
            end
            B_UWAIT:
            begin
                u_reg[0] <= -nrx; u_reg[1] <= -nry; u_reg[2] <= -nrz;
                ax_reg   <= 2'd0;
            end
            B_EMIT:
            begin
                if (ofree)
                begin
                    ax_reg <= ax_reg + 2'd1;
                    case (ax_reg)
                        2'd0: odata_reg <= '{item_kind: KIND_AXIS, item_index: AXIS_RIGHT,
                                   out_x: r_reg[0], out_y: r_reg[1], out_z: r_reg[2],
                                   overflow: 1'b0, last: 1'b0};
                        2'd1: odata_reg <= '{item_kind: KIND_AXIS, item_index: AXIS_UP,
                                   out_x: u_reg[0], out_y: u_reg[1], out_z: u_reg[2],
                                   overflow: 1'b0, last: 1'b0};
                        default: odata_reg <= '{item_kind: KIND_AXIS, item_index: AXIS_FRONT,
                                   out_x: f_reg[0], out_y: f_reg[1], out_z: f_reg[2],
                                   overflow: 1'b0, last: 1'b1};
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule

// ===== design/obb_checker.sv =====
module obb_checker
    import obb_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);
    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // Only the front axis is last.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.item_kind == KIND_AXIS
            && out_data.item_index == AXIS_FRONT)
        else $error("last on wrong item");

    // Axes never report overflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.item_kind == KIND_AXIS |-> !out_data.overflow)
        else $error("overflow on axis");
endmodule

bind obb_axes_and_corner_transform_top obb_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
